>>> src/ipaf_pkg.sv
// ----------------------------------------------------------------------------
// ipaf_pkg
// Shared types, character codes and helper functions for the address text
// formatter.
// ----------------------------------------------------------------------------
package ipaf_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_HEX_A = 8'h61;

  localparam logic [2:0] PRE_END_MAPPED = 3'd6;
  localparam logic [2:0] PRE_END_COMPAT = 3'd1;

  localparam logic [1:0] DIG_HUND = 2'd0;
  localparam logic [1:0] DIG_TENS = 2'd1;
  localparam logic [1:0] DIG_ONES = 2'd2;

  typedef enum logic [1:0] {
    MODE_V4,
    MODE_MAPPED,
    MODE_COMPAT,
    MODE_HEX
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [127:0] addr;
    logic [2:0]   best_start;
    logic [3:0]   best_len;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  typedef struct packed {
    logic  avail;
    desc_t desc;
  } q_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_PRE,
    ST_DEC,
    ST_DOT,
    ST_HEX_DIG,
    ST_HEX_COLON,
    ST_HEX_RUN
  } state_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  function automatic dec_t octet_digits(input logic [7:0] v);
    dec_t       d;
    logic [7:0] r;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      r = v - 8'd100;
    end else begin
      d.hund = 4'd0;
      r = v;
    end
    d.tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(10 * k)) begin
        d.tens = 4'(k);
      end
    end
    d.ones = 4'(r - ({4'b0, d.tens} * 8'd10));
    return d;
  endfunction

  function automatic logic [1:0] first_digit(input logic [7:0] v);
    if (v >= 8'd100) begin
      return DIG_HUND;
    end else if (v >= 8'd10) begin
      return DIG_TENS;
    end
    return DIG_ONES;
  endfunction

  function automatic logic [1:0] first_nib(input logic [15:0] g);
    if (g[15:12] != 4'd0) begin
      return 2'd0;
    end else if (g[11:8] != 4'd0) begin
      return 2'd1;
    end else if (g[7:4] != 4'd0) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + {4'b0, n};
    end
    return CH_HEX_A + {4'b0, n} - 8'd10;
  endfunction

  // "::ffff:"
  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    unique case (p) inside
      3'd0, 3'd1, 3'd6: c = CH_COLON;
      default:          c = CH_F;
    endcase
    return c;
  endfunction

endpackage

>>> src/ipaf_front.sv
// ----------------------------------------------------------------------------
// ipaf_front
// Accepts addresses, picks the print form and finds the first longest run of
// zero groups, then hands a descriptor to the queue.
// ----------------------------------------------------------------------------
module ipaf_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [63:0]          addr_high,
  input  logic [63:0]          addr_low,
  input  logic                 q_full,
  output ipaf_pkg::q_wr_t      q_wr
);

  logic [7:0]      zero;
  logic [3:0]      run [8];
  logic [3:0]      cnt;
  logic [2:0]      best_start;
  logic [3:0]      best_len;
  ipaf_pkg::mode_t mode;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      zero[i]     = (addr_high[48 - 16 * i +: 16] == 16'd0);
      zero[i + 4] = (addr_low[48 - 16 * i +: 16] == 16'd0);
    end
  end

  always_comb begin
    cnt = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      cnt    = zero[i] ? cnt + 4'd1 : 4'd0;
      run[i] = cnt;
    end
  end

  always_comb begin
    best_start = 3'd0;
    best_len   = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (run[i] > best_len) begin
        best_start = 3'(i);
        best_len   = run[i];
      end
    end
  end

  always_comb begin
    if (!command) begin
      mode = ipaf_pkg::MODE_V4;
    end else if (addr_high == 64'd0 && addr_low[63:32] == 32'h0000ffff) begin
      mode = ipaf_pkg::MODE_MAPPED;
    end else if (addr_high == 64'd0 && addr_low[63:32] == 32'd0 &&
                 addr_low[31:0] > 32'd1) begin
      mode = ipaf_pkg::MODE_COMPAT;
    end else begin
      mode = ipaf_pkg::MODE_HEX;
    end
  end

  assign in_stall             = q_full;
  assign q_wr.push            = in_valid && !q_full;
  assign q_wr.desc.mode       = mode;
  assign q_wr.desc.addr       = {addr_high, addr_low};
  assign q_wr.desc.best_start = best_start;
  assign q_wr.desc.best_len   = best_len;

endmodule

>>> src/ipaf_queue.sv
// ----------------------------------------------------------------------------
// ipaf_queue
// Two-entry descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module ipaf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  ipaf_pkg::q_wr_t      q_wr,
  output logic                 q_full,
  input  logic                 pop,
  output ipaf_pkg::q_rd_t      q_rd
);

  ipaf_pkg::desc_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_pop;

  assign q_full     = (count == 2'd2);
  assign q_rd.avail = (count != 2'd0);
  assign q_rd.desc  = entries[rd_ptr];
  assign do_pop     = pop && q_rd.avail;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      entries[wr_ptr] <= q_wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_wr.push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/ipaf_back.sv
// ----------------------------------------------------------------------------
// ipaf_back
// Character sequencer: walks one descriptor and emits one character per
// cycle into the output register unless out_stall holds it.
// ----------------------------------------------------------------------------
module ipaf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ipaf_pkg::q_rd_t      q_rd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           char_code,
  output logic                 last
);

  ipaf_pkg::state_t state, state_next;
  ipaf_pkg::desc_t  desc;
  logic [2:0]       grp, grp_next;
  logic [1:0]       nib, nib_next;
  logic [1:0]       oct, oct_next;
  logic [1:0]       dig, dig_next;
  logic [2:0]       pre, pre_next;
  logic             sub, sub_next;

  logic             emitting;
  logic             adv;
  logic [7:0]       emit_char;
  logic             emit_last;

  logic [15:0]      grp_val;
  logic [7:0]       oct_val;
  ipaf_pkg::dec_t   digits;
  logic [3:0]       run_end;
  logic [2:0]       pre_end;

  logic [2:0]       enter_g;
  logic [15:0]      enter_g_val;
  logic             enter_is_run;
  logic [1:0]       enter_oct;
  logic [7:0]       enter_oct_val;

  assign grp_val       = desc.addr[{~grp, 4'b0000} +: 16];
  assign oct_val       = desc.addr[{~oct, 3'b000} +: 8];
  assign digits        = ipaf_pkg::octet_digits(oct_val);
  assign run_end       = {1'b0, grp} + desc.best_len;
  assign pre_end       = (desc.mode == ipaf_pkg::MODE_MAPPED) ?
                         ipaf_pkg::PRE_END_MAPPED : ipaf_pkg::PRE_END_COMPAT;

  assign enter_g_val   = desc.addr[{~enter_g, 4'b0000} +: 16];
  assign enter_is_run  = (desc.best_len != 4'd0) && (enter_g == desc.best_start);
  assign enter_oct_val = desc.addr[{~enter_oct, 3'b000} +: 8];

  assign emitting = (state != ipaf_pkg::ST_IDLE) && (state != ipaf_pkg::ST_START);
  assign adv      = emitting && (!out_valid || !out_stall);
  assign pop      = (state == ipaf_pkg::ST_IDLE);

  always_comb begin
    case (state)
      ipaf_pkg::ST_HEX_COLON: enter_g = grp + 3'd1;
      ipaf_pkg::ST_HEX_RUN:   enter_g = run_end[2:0];
      default:                enter_g = 3'd0;
    endcase
    enter_oct = (state == ipaf_pkg::ST_DOT) ? oct + 2'd1 : 2'd0;
  end

  // next state and counters
  always_comb begin
    state_next = state;
    grp_next   = grp;
    nib_next   = nib;
    oct_next   = oct;
    dig_next   = dig;
    pre_next   = pre;
    sub_next   = sub;
    unique case (state)
      ipaf_pkg::ST_IDLE: begin
        if (q_rd.avail) begin
          state_next = ipaf_pkg::ST_START;
        end
      end
      ipaf_pkg::ST_START: begin
        oct_next = 2'd0;
        pre_next = 3'd0;
        dig_next = ipaf_pkg::first_digit(enter_oct_val);
        unique case (desc.mode) inside
          ipaf_pkg::MODE_V4:                           state_next = ipaf_pkg::ST_DEC;
          ipaf_pkg::MODE_MAPPED, ipaf_pkg::MODE_COMPAT: state_next = ipaf_pkg::ST_PRE;
          default: begin
            grp_next   = enter_g;
            sub_next   = 1'b0;
            nib_next   = ipaf_pkg::first_nib(enter_g_val);
            state_next = enter_is_run ? ipaf_pkg::ST_HEX_RUN : ipaf_pkg::ST_HEX_DIG;
          end
        endcase
      end
      ipaf_pkg::ST_PRE: begin
        if (adv) begin
          if (pre == pre_end) begin
            state_next = ipaf_pkg::ST_DEC;
            oct_next   = 2'd0;
            dig_next   = ipaf_pkg::first_digit(enter_oct_val);
          end else begin
            pre_next = pre + 3'd1;
          end
        end
      end
      ipaf_pkg::ST_DEC: begin
        if (adv) begin
          if (dig == ipaf_pkg::DIG_ONES) begin
            state_next = (oct == 2'd3) ? ipaf_pkg::ST_IDLE : ipaf_pkg::ST_DOT;
          end else begin
            dig_next = dig + 2'd1;
          end
        end
      end
      ipaf_pkg::ST_DOT: begin
        if (adv) begin
          state_next = ipaf_pkg::ST_DEC;
          oct_next   = enter_oct;
          dig_next   = ipaf_pkg::first_digit(enter_oct_val);
        end
      end
      ipaf_pkg::ST_HEX_DIG: begin
        if (adv) begin
          if (nib == 2'd3) begin
            state_next = (grp == 3'd7) ? ipaf_pkg::ST_IDLE : ipaf_pkg::ST_HEX_COLON;
          end else begin
            nib_next = nib + 2'd1;
          end
        end
      end
      ipaf_pkg::ST_HEX_COLON: begin
        if (adv) begin
          grp_next   = enter_g;
          sub_next   = 1'b0;
          nib_next   = ipaf_pkg::first_nib(enter_g_val);
          state_next = enter_is_run ? ipaf_pkg::ST_HEX_RUN : ipaf_pkg::ST_HEX_DIG;
        end
      end
      ipaf_pkg::ST_HEX_RUN: begin
        if (adv) begin
          if (grp == 3'd0 && !sub) begin
            sub_next = 1'b1;
          end else if (run_end[3]) begin
            state_next = ipaf_pkg::ST_IDLE;
          end else begin
            grp_next   = enter_g;
            sub_next   = 1'b0;
            nib_next   = ipaf_pkg::first_nib(enter_g_val);
            state_next = enter_is_run ? ipaf_pkg::ST_HEX_RUN : ipaf_pkg::ST_HEX_DIG;
          end
        end
      end
      default: state_next = ipaf_pkg::ST_IDLE;
    endcase
  end

  // character for the current step
  always_comb begin
    emit_char = ipaf_pkg::CH_COLON;
    emit_last = 1'b0;
    unique case (state)
      ipaf_pkg::ST_PRE: emit_char = ipaf_pkg::prefix_char(pre);
      ipaf_pkg::ST_DEC: begin
        case (dig)
          ipaf_pkg::DIG_HUND: emit_char = ipaf_pkg::CH_ZERO + {4'b0, digits.hund};
          ipaf_pkg::DIG_TENS: emit_char = ipaf_pkg::CH_ZERO + {4'b0, digits.tens};
          default:            emit_char = ipaf_pkg::CH_ZERO + {4'b0, digits.ones};
        endcase
        emit_last = (dig == ipaf_pkg::DIG_ONES) && (oct == 2'd3);
      end
      ipaf_pkg::ST_DOT: emit_char = ipaf_pkg::CH_DOT;
      ipaf_pkg::ST_HEX_DIG: begin
        emit_char = ipaf_pkg::hex_char(grp_val[{~nib, 2'b00} +: 4]);
        emit_last = (nib == 2'd3) && (grp == 3'd7);
      end
      ipaf_pkg::ST_HEX_RUN: begin
        emit_last = !(grp == 3'd0 && !sub) && run_end[3];
      end
      default: emit_char = ipaf_pkg::CH_COLON;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ipaf_pkg::ST_IDLE && q_rd.avail) begin
      desc <= q_rd.desc;
    end
    grp <= grp_next;
    nib <= nib_next;
    oct <= oct_next;
    dig <= dig_next;
    pre <= pre_next;
    sub <= sub_next;
    if (adv) begin
      char_code <= emit_char;
      last      <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipaf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/ip_address_text_formatter_unit.sv
// ----------------------------------------------------------------------------
// ip_address_text_formatter_unit
// Prints a binary IPv4 or IPv6 address as ASCII text, one character per
// output transaction, flagging the last character.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   command, addr_high, addr_low
//   out      output     out_valid / out_stall char_code, last
//
// One character leaves per cycle while out_stall is low; an address also passes
// through the idle and start states of the back sequencer. A two-entry queue
// lets the front take new addresses meanwhile.
// Reset (rst, synchronous) empties the queue and the output register.
// out_stall holds the output register and pauses the sequencer; in_stall
// rises only while the queue is full.
// ----------------------------------------------------------------------------
module ip_address_text_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_code,
  output logic        last
);

  ipaf_pkg::q_wr_t q_wr;
  ipaf_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            pop;

  ipaf_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  ipaf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  ipaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

endmodule

>>> tb/tb_ip_address_text_formatter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_formatter_unit
// Sends IPv4 and IPv6 addresses into the formatter and checks every character
// that comes out, and its last flag, against text built in the testbench.
// Directed addresses cover the corner cases first. Random addresses follow,
// with bursty input, a stalling receiver and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_ip_address_text_formatter_unit;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  class address_text_scoreboard;
    char_item_t expected_chars[$];
    logic [7:0] text[$];
    int         errors = 0;

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_chars.size();
    endfunction

    function void put_octet(logic [7:0] v);
      if (v >= 8'd100) text.push_back("0" + 8'(v / 8'd100));
      if (v >= 8'd10) text.push_back("0" + 8'((v / 8'd10) % 8'd10));
      text.push_back("0" + 8'(v % 8'd10));
    endfunction

    function void put_dotted(logic [31:0] a);
      for (int i = 0; i < 4; i++) begin
        put_octet(a[31 - 8 * i -: 8]);
        if (i != 3) text.push_back(".");
      end
    endfunction

    function void put_group(logic [15:0] g);
      logic       started;
      logic [3:0] nib;
      started = 1'b0;
      for (int s = 3; s >= 0; s--) begin
        nib = g[4 * s +: 4];
        if (nib != 4'd0 || started || s == 0) begin
          started = 1'b1;
          text.push_back(nib < 4'd10 ? "0" + 8'(nib) : "a" + 8'(nib) - 8'd10);
        end
      end
    endfunction

    function void put_ipv6(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] a;
      logic [15:0]  grp[8];
      int           run_len[8];
      int           count, best, best_len, i;
      if (hi == 64'd0 && lo[63:32] == 32'h0000_ffff) begin
        text.push_back(":");
        text.push_back(":");
        repeat (4) text.push_back("f");
        text.push_back(":");
        put_dotted(lo[31:0]);
        return;
      end
      if (hi == 64'd0 && lo[63:32] == 32'd0 && lo[31:0] > 32'd1) begin
        text.push_back(":");
        text.push_back(":");
        put_dotted(lo[31:0]);
        return;
      end
      a = {hi, lo};
      for (i = 0; i < 8; i++) grp[i] = a[127 - 16 * i -: 16];
      count = 0;
      for (i = 7; i >= 0; i--) begin
        count = (grp[i] == 16'd0) ? count + 1 : 0;
        run_len[i] = count;
      end
      best = -1;
      best_len = 0;
      for (i = 0; i < 8; i++) begin
        if (run_len[i] > best_len) begin
          best = i;
          best_len = run_len[i];
        end
      end
      i = 0;
      while (i < 8) begin
        if (i == best) begin
          if (i == 0) text.push_back(":");
          text.push_back(":");
          i += best_len;
        end else begin
          put_group(grp[i]);
          if (i != 7) text.push_back(":");
          i++;
        end
      end
    endfunction

    // transaction accepted on the input side
    function void note_address(logic cmd, logic [63:0] hi, logic [63:0] lo);
      char_item_t item;
      text.delete();
      if (!cmd) put_dotted(lo[31:0]);
      else put_ipv6(hi, lo);
      foreach (text[k]) begin
        item.code = text[k];
        item.last = (k == text.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    task check_char(input logic [7:0] code, input logic lst);
      char_item_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", code, lst));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("char_code %h, want %h", code, want.code));
      if (lst !== want.last)
        report_mismatch($sformatf("last %b on char %h, want %b", lst, want.code, want.last));
    endtask

    task report_leftovers();
      if (expected_chars.size() != 0)
        report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  char_code;
  logic        last;

  address_text_scoreboard sb;
  bit                     hold_req;
  int                     burst_left;

  ip_address_text_formatter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(char_code, last);
  end

  // receiver: random stall stretches, plus long hold-offs on request
  initial begin
    int phase_left, stall_pct, hold_left;
    phase_left = 0;
    stall_pct = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic offer_address(input logic c, input logic [63:0] h, input logic [63:0] l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    command   <= c;
    addr_high <= h;
    addr_low  <= l;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_address(c, h, l);
  endtask

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 9));
      3: return 8'($urandom_range(10, 99));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'd0;
      4: return 16'hffff;
      5: return 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_random_address(output logic c, output logic [63:0] h,
                                     output logic [63:0] l);
    logic [127:0] a;
    int           kind;
    kind = $urandom_range(0, 9);
    h = {$urandom, $urandom};
    l = {$urandom, $urandom};
    if (kind < 3) begin
      c = 1'b0;
      l[31:0] = {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
    end else if (kind == 3) begin
      c = 1'b1;
      h = 64'd0;
      l[63:32] = 32'h0000_ffff;
      if ($urandom_range(0, 1)) l[31:0] = {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
    end else if (kind == 4) begin
      c = 1'b1;
      h = 64'd0;
      l[63:32] = 32'd0;
      if ($urandom_range(0, 2) == 0) l[31:0] = $urandom_range(0, 3);
    end else begin
      c = 1'b1;
      for (int i = 0; i < 8; i++) a[127 - 16 * i -: 16] = rand_group();
      {h, l} = a;
    end
  endtask

  initial begin
    logic        c;
    logic [63:0] h, l;
    int          guard;
    sb = new;
    hold_req = 1'b0;
    burst_left = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    command   <= 1'b0;
    addr_high <= 64'd0;
    addr_low  <= 64'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: IPv4
    offer_address(1'b0, 64'd0, 64'd0);
    offer_address(1'b0, '1, '1);
    offer_address(1'b0, 64'hdead_beef_0123_4567, 64'h1234_5678_0a00_6409);
    offer_address(1'b0, 64'd0, 64'h0000_0000_0102_0304);
    offer_address(1'b0, 64'd0, 64'hffff_ffff_6364_090a);
    offer_address(1'b0, 64'd0, 64'h0000_ffff_0000_0000);
    // directed: IPv6 special forms
    offer_address(1'b1, 64'd0, 64'd0);
    offer_address(1'b1, 64'd0, 64'd1);
    offer_address(1'b1, 64'd0, 64'h0000_ffff_0000_0000);
    offer_address(1'b1, 64'd0, 64'h0000_ffff_ffff_ffff);
    offer_address(1'b1, 64'd0, 64'd2);
    offer_address(1'b1, 64'd0, 64'h0000_0000_ffff_ffff);
    offer_address(1'b1, 64'd0, 64'h0000_0001_0000_0000);
    offer_address(1'b1, 64'd1, 64'h0000_ffff_0102_0304);
    // directed: IPv6 hex groups and zero runs
    offer_address(1'b1, '1, '1);
    offer_address(1'b1, 64'h2001_0db8_0000_0000, 64'h0001_0000_0000_0001);
    offer_address(1'b1, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007);
    offer_address(1'b1, 64'hfe80_0000_0000_0000, 64'd0);
    offer_address(1'b1, 64'd0, 64'h0001_0000_0000_0000);
    offer_address(1'b1, 64'h0000_0000_0000_0001, 64'd0);
    offer_address(1'b1, 64'h0001_0010_0100_1000, 64'h000f_00f0_0f00_f000);
    offer_address(1'b1, 64'habcd_ef01_2345_6789, 64'h0000_0000_0000_0000);
    offer_address(1'b1, 64'h0000_ffff_0000_0000, 64'h0000_0000_1234_0000);

    // random; receiver holds off at the start and midway to back up the queue
    hold_req = 1'b1;
    for (int n = 0; n < 387; n++) begin
      if (n == 200) hold_req = 1'b1;
      pick_random_address(c, h, l);
      offer_address(c, h, l);
    end
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
src/ipaf_pkg.sv
src/ipaf_front.sv
src/ipaf_queue.sv
src/ipaf_back.sv
src/ip_address_text_formatter_unit.sv
tb/tb_ip_address_text_formatter_unit.sv
